/* hw/rtl/lob_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order book package
// Shared widths, command and status codes, cell control types.
// ----------------------------------------------------------------------------
package lob_pkg;

   localparam int ID_BITS        = 32;
   localparam int PRICE_BITS     = 20;
   localparam int QTY_BITS       = 32;
   localparam int TOTAL_BITS     = 40;
   localparam int CMD_BITS       = 2;
   localparam int STATUS_BITS    = 3;
   localparam int MAX_ORDERS_DEF = 256;
   localparam int MAX_LEVELS_DEF = 64;

   // commands
   localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CANCEL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_MODIFY = 2'd2;

   // result status
   localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_BAD_QTY   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_DUP       = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_INCREASE  = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_REJECTED  = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd6;

   typedef enum logic [1:0] {ORD_NOP, ORD_LOAD, ORD_CLEAR, ORD_SETQ} ord_op_type;

   typedef struct packed {
      ord_op_type                op;
      logic [ID_BITS-1:0]        id;
      logic                      side;
      logic [PRICE_BITS-1:0]     price;
      logic [QTY_BITS-1:0]       qty;
   } ord_ctl_type;

   typedef struct packed {
      logic                      side;
      logic [PRICE_BITS-1:0]     price;
      logic [QTY_BITS-1:0]       qty;
   } ord_data_type;

   typedef enum logic [2:0] {LVL_NOP, LVL_CREATE, LVL_ADD, LVL_SUB, LVL_REMOVE} lvl_op_type;

   typedef struct packed {
      lvl_op_type                op;
      logic [PRICE_BITS-1:0]     price;
      logic [QTY_BITS-1:0]       amount;
   } lvl_ctl_type;

   typedef struct packed {
      logic                      valid;
      logic [PRICE_BITS-1:0]     price;
      logic [TOTAL_BITS-1:0]     total;
   } lvl_entry_type;

endpackage
`default_nettype wire

/* hw/rtl/lob_order_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Order cell
// Holds one resting order, matches its id and passes the free-slot token on.
// ----------------------------------------------------------------------------
module lob_order_cell (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       sel,
   input  wire lob_pkg::ord_ctl_type ctl,
   input  wire                       free_before_in,
   output logic                      free_before_out,
   output logic                      take,
   output logic                      hit,
   output lob_pkg::ord_data_type     data
);

   logic                          valid_ff, valid_in;
   logic [lob_pkg::ID_BITS-1:0]   key_ff, key_in;
   lob_pkg::ord_data_type         data_ff, data_in;

   // id match and lowest-free token
   assign hit             = valid_ff && (key_ff == ctl.id);
   assign take            = !valid_ff && !free_before_in;
   assign free_before_out = free_before_in || !valid_ff;
   assign data            = data_ff;

   // update
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (sel) begin
         unique case (ctl.op)
            lob_pkg::ORD_LOAD: begin
               valid_in      = 1'b1;
               key_in        = ctl.id;
               data_in.side  = ctl.side;
               data_in.price = ctl.price;
               data_in.qty   = ctl.qty;
            end
            lob_pkg::ORD_CLEAR: valid_in    = 1'b0;
            lob_pkg::ORD_SETQ:  data_in.qty = ctl.qty;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff  <= key_in;
      data_ff <= data_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/lob_level_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Price level cell
// Holds one price level of one side: price, summed quantity, order count.
// ----------------------------------------------------------------------------
module lob_level_cell #(
   parameter int CNT_W = 9
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           sel,
   input  wire lob_pkg::lvl_ctl_type     ctl,
   input  wire [lob_pkg::PRICE_BITS-1:0] query_price,
   input  wire                           free_before_in,
   output logic                          free_before_out,
   output logic                          take,
   output logic                          hit,
   output lob_pkg::lvl_entry_type        entry
);

   logic                          valid_ff, valid_in;
   logic [lob_pkg::PRICE_BITS-1:0] price_ff, price_in;
   logic [lob_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [lob_pkg::TOTAL_BITS-1:0] amount_ext;

   assign hit             = valid_ff && (price_ff == query_price);
   assign take            = !valid_ff && !free_before_in;
   assign free_before_out = free_before_in || !valid_ff;
   assign entry           = '{valid: valid_ff, price: price_ff, total: total_ff};
   assign amount_ext      = {{(lob_pkg::TOTAL_BITS-lob_pkg::QTY_BITS){1'b0}}, ctl.amount};

   // level update, totals wrap modulo 2^40
   always_comb begin
      valid_in = valid_ff;
      price_in = price_ff;
      total_in = total_ff;
      cnt_in   = cnt_ff;
      if (sel) begin
         unique case (ctl.op)
            lob_pkg::LVL_CREATE: begin
               valid_in = 1'b1;
               price_in = ctl.price;
               total_in = amount_ext;
               cnt_in   = CNT_W'(1);
            end
            lob_pkg::LVL_ADD: begin
               total_in = total_ff + amount_ext;
               cnt_in   = cnt_ff + CNT_W'(1);
            end
            lob_pkg::LVL_SUB: total_in = total_ff - amount_ext;
            lob_pkg::LVL_REMOVE: begin
               total_in = total_ff - amount_ext;
               cnt_in   = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  valid_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      price_ff <= price_in;
      total_ff <= total_in;
      cnt_ff   <= cnt_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/lob_best_tree.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Best level tree
// Registered compare tree over the level cells of one side.
// ----------------------------------------------------------------------------
module lob_best_tree #(
   parameter int N        = 64,
   parameter bit FIND_MAX = 1'b1
) (
   input  wire                         clock,
   input  wire lob_pkg::lvl_entry_type leaf [N],
   output lob_pkg::lvl_entry_type      best
);

   localparam int P     = 1 << $clog2(N);
   localparam int NODES = 2 * P - 1;

   lob_pkg::lvl_entry_type node_ff [NODES];

   function automatic lob_pkg::lvl_entry_type pick(input lob_pkg::lvl_entry_type a,
                                                   input lob_pkg::lvl_entry_type b);
      logic better;
      better = FIND_MAX ? (b.price > a.price) : (b.price < a.price);
      if (!a.valid) begin
         return b;
      end else if (b.valid && better) begin
         return b;
      end
      return a;
   endfunction

   // leaves, padded with empty entries
   for (genvar j = 0; j < P; j++) begin : g_leaf
      if (j < N) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[P-1+j] <= leaf[j];
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[P-1+j] <= '0;
         end
      end
   end

   // internal nodes
   for (genvar i = 0; i < P - 1; i++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[i] <= pick(node_ff[2*i+1], node_ff[2*i+2]);
      end
   end

   // empty side reports zero price and total
   always_comb begin
      best = node_ff[0];
      if (!node_ff[0].valid) begin
         best = '0;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/limit_order_book_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order book unit
// Two-sided order book with price level aggregation, no matching.
// ----------------------------------------------------------------------------
// One command is handled at a time. From the input transfer to the result it
// passes through the id search over the row of order cells, the level search
// over the row of level cells, an update step, the registered best-price tree
// (clog2(MAX_LEVELS) + 1 stages) settling, and the load of the output
// register, which waits while an earlier result there is not yet taken. The
// next command is taken only after that load, not while one is in flight.
// A finished result waits in the output register while the next command is
// taken. Free order and level slots are found by a token passed along each
// row of cells, so the lowest free slot is always used.
// ----------------------------------------------------------------------------
module limit_order_book_unit #(
   parameter int MAX_ORDERS = lob_pkg::MAX_ORDERS_DEF,
   parameter int MAX_LEVELS = lob_pkg::MAX_LEVELS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [87:0]  req_tdata,   // order_id, side, price, quantity, zero pad
   input  wire  [1:0]   req_tuser,   // command
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,  // best_bid_valid, best_bid_price,
                                     // best_bid_total, best_ask_valid,
                                     // best_ask_price, best_ask_total, zero pad
   output logic [2:0]   rsp_tuser    // status
);

   localparam int CNT_W    = $clog2(MAX_ORDERS + 1);
   localparam int TREE_LAT = $clog2(MAX_LEVELS) + 1;
   localparam int WAIT_W   = $clog2(TREE_LAT + 1);
   localparam int PB       = lob_pkg::PRICE_BITS;
   localparam int QB       = lob_pkg::QTY_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FIND  = 3'd1;
   localparam logic [2:0] S_LEVEL = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_BEST  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [WAIT_W-1:0]            wait_ff;
   logic [lob_pkg::CMD_BITS-1:0] cmd_ff;
   logic [lob_pkg::ID_BITS-1:0]  id_ff;
   logic                         side_ff;
   logic [PB-1:0]                price_ff;
   logic [QB-1:0]                qty_ff;

   logic [MAX_ORDERS-1:0]        ord_hit, ord_take, ord_hit_ff, ord_take_ff;
   logic [MAX_ORDERS:0]          ord_chain;
   logic                         ord_found_ff, ord_free_ff;
   lob_pkg::ord_data_type        ord_data [MAX_ORDERS];
   lob_pkg::ord_data_type        ord_rd, ord_rd_ff;
   lob_pkg::ord_ctl_type         ord_ctl;
   logic [MAX_ORDERS-1:0]        ord_sel;

   logic [1:0][MAX_LEVELS-1:0]   lvl_hit, lvl_take;
   logic [1:0][MAX_LEVELS:0]     lvl_chain;
   logic [MAX_LEVELS-1:0]        lvl_hit_ff, lvl_take_ff;
   logic                         lvl_found_ff, lvl_free_ff, lvl_side_ff;
   logic                         q_side;
   logic [PB-1:0]                q_price;
   lob_pkg::lvl_entry_type       lvl_entry [2][MAX_LEVELS];
   lob_pkg::lvl_ctl_type         lvl_ctl;
   logic [MAX_LEVELS-1:0]        lvl_vec;
   logic [1:0][MAX_LEVELS-1:0]   lvl_sel;
   lob_pkg::lvl_entry_type       best_bid, best_ask;

   logic [lob_pkg::STATUS_BITS-1:0] status, status_ff;
   logic                            rsp_valid_ff;
   logic [127:0]                    rsp_data_ff;
   logic [2:0]                      rsp_user_ff;
   logic                            rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // row of order cells
   assign ord_chain[0] = 1'b0;
   for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_ord
      lob_order_cell u_cell (
         .clock           (clock),
         .reset           (reset),
         .sel             (ord_sel[i]),
         .ctl             (ord_ctl),
         .free_before_in  (ord_chain[i]),
         .free_before_out (ord_chain[i+1]),
         .take            (ord_take[i]),
         .hit             (ord_hit[i]),
         .data            (ord_data[i])
      );
   end

   // fields of the matching order
   always_comb begin
      ord_rd = '0;
      for (int i = 0; i < MAX_ORDERS; i++) begin
         if (ord_hit[i]) begin
            ord_rd = ord_rd | ord_data[i];
         end
      end
   end

   // level search key: request for add, resting order otherwise
   assign q_side  = (cmd_ff == lob_pkg::CMD_ADD) ? side_ff  : ord_rd_ff.side;
   assign q_price = (cmd_ff == lob_pkg::CMD_ADD) ? price_ff : ord_rd_ff.price;

   // rows of level cells, bid then ask
   for (genvar s = 0; s < 2; s++) begin : g_side
      assign lvl_chain[s][0] = 1'b0;
      for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_lvl
         lob_level_cell #(.CNT_W(CNT_W)) u_cell (
            .clock           (clock),
            .reset           (reset),
            .sel             (lvl_sel[s][i]),
            .ctl             (lvl_ctl),
            .query_price     (q_price),
            .free_before_in  (lvl_chain[s][i]),
            .free_before_out (lvl_chain[s][i+1]),
            .take            (lvl_take[s][i]),
            .hit             (lvl_hit[s][i]),
            .entry           (lvl_entry[s][i])
         );
      end
   end

   lob_best_tree #(.N(MAX_LEVELS), .FIND_MAX(1'b1)) u_bid_tree (
      .clock (clock),
      .leaf  (lvl_entry[0]),
      .best  (best_bid)
   );

   lob_best_tree #(.N(MAX_LEVELS), .FIND_MAX(1'b0)) u_ask_tree (
      .clock (clock),
      .leaf  (lvl_entry[1]),
      .best  (best_ask)
   );

   // command decode and cell updates
   always_comb begin
      status       = lob_pkg::ST_OK;
      ord_ctl      = '{op: lob_pkg::ORD_NOP, id: id_ff, side: side_ff,
                       price: price_ff, qty: qty_ff};
      ord_sel      = '0;
      lvl_ctl      = '{op: lob_pkg::LVL_NOP, price: price_ff, amount: qty_ff};
      lvl_vec      = '0;
      if (state_ff == S_EXEC) begin
         unique case (cmd_ff)
            lob_pkg::CMD_ADD: begin
               priority if (qty_ff == '0) begin
                  status = lob_pkg::ST_BAD_QTY;
               end else if (ord_found_ff) begin
                  status = lob_pkg::ST_DUP;
               end else if (!ord_free_ff || (!lvl_found_ff && !lvl_free_ff)) begin
                  status = lob_pkg::ST_FULL;
               end else begin
                  ord_ctl.op = lob_pkg::ORD_LOAD;
                  ord_sel    = ord_take_ff;
                  if (lvl_found_ff) begin
                     lvl_ctl.op = lob_pkg::LVL_ADD;
                     lvl_vec    = lvl_hit_ff;
                  end else begin
                     lvl_ctl.op = lob_pkg::LVL_CREATE;
                     lvl_vec    = lvl_take_ff;
                  end
               end
            end
            lob_pkg::CMD_CANCEL, lob_pkg::CMD_MODIFY: begin
               priority if (!ord_found_ff) begin
                  status = lob_pkg::ST_NOT_FOUND;
               end else if (cmd_ff == lob_pkg::CMD_CANCEL || qty_ff == '0) begin
                  ord_ctl.op     = lob_pkg::ORD_CLEAR;
                  ord_sel        = ord_hit_ff;
                  lvl_ctl.op     = lob_pkg::LVL_REMOVE;
                  lvl_ctl.amount = ord_rd_ff.qty;
                  lvl_vec        = lvl_hit_ff;
               end else if (qty_ff > ord_rd_ff.qty) begin
                  status = lob_pkg::ST_INCREASE;
               end else begin
                  ord_ctl.op     = lob_pkg::ORD_SETQ;
                  ord_sel        = ord_hit_ff;
                  lvl_ctl.op     = lob_pkg::LVL_SUB;
                  lvl_ctl.amount = ord_rd_ff.qty - qty_ff;
                  lvl_vec        = lvl_hit_ff;
               end
            end
            default: status = lob_pkg::ST_REJECTED;
         endcase
      end
   end

   assign lvl_sel[0] = lvl_side_ff ? '0 : lvl_vec;
   assign lvl_sel[1] = lvl_side_ff ? lvl_vec : '0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_FIND;
         S_FIND:  state_in = S_LEVEL;
         S_LEVEL: state_in = S_EXEC;
         S_EXEC:  state_in = S_BEST;
         S_BEST:  if (wait_ff == WAIT_W'(TREE_LAT - 1)) state_in = S_DONE;
         S_DONE:  if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         cmd_ff   <= req_tuser;
         id_ff    <= req_tdata[31:0];
         side_ff  <= req_tdata[32];
         price_ff <= req_tdata[52:33];
         qty_ff   <= req_tdata[84:53];
      end
      if (state_ff == S_FIND) begin
         ord_hit_ff   <= ord_hit;
         ord_take_ff  <= ord_take;
         ord_found_ff <= |ord_hit;
         ord_free_ff  <= ord_chain[MAX_ORDERS];
         ord_rd_ff    <= ord_rd;
      end
      if (state_ff == S_LEVEL) begin
         lvl_side_ff  <= q_side;
         lvl_hit_ff   <= lvl_hit[q_side];
         lvl_take_ff  <= lvl_take[q_side];
         lvl_found_ff <= |lvl_hit[q_side];
         lvl_free_ff  <= lvl_chain[q_side][MAX_LEVELS];
      end
      if (state_ff == S_EXEC) begin
         status_ff <= status;
         wait_ff   <= '0;
      end else if (state_ff == S_BEST) begin
         wait_ff <= wait_ff + WAIT_W'(1);
      end
      if (rsp_load) begin
         rsp_user_ff <= status_ff;
         rsp_data_ff <= {6'd0, best_ask.total, best_ask.price, best_ask.valid,
                         best_bid.total, best_bid.price, best_bid.valid};
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/lob_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Limit order book port checker
// Port-level properties of the order book unit, bound to the top level.
// ----------------------------------------------------------------------------
module lob_checker (
   input wire         clock,
   input wire         reset,
   input wire         req_tvalid,
   input wire         req_tready,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [127:0] rsp_tdata,
   input wire [2:0]   rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an empty side reports zero price and total
   a_empty_bid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[60:1] == '0)
      else $error("empty bid side not zero");

   a_empty_ask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[61] |-> rsp_tdata[121:62] == '0)
      else $error("empty ask side not zero");

   // one command in flight: no input transfer right after one
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while busy");

   // a new result never appears the cycle after an input transfer
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result too early");

endmodule

bind limit_order_book_unit lob_checker u_lob_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* dv/limit_order_book_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limit order book unit testbench
// Drives add, cancel and modify commands over the request stream and checks
// every response against an in-bench model of the order and level tables.
// A directed table comes first, then random traffic over a small id and price
// pool so that duplicates, misses and full tables occur, under several
// backpressure phases.
// ----------------------------------------------------------------------------
module limit_order_book_unit_tb;

   localparam int N_ORD     = lob_pkg::MAX_ORDERS_DEF;
   localparam int N_LVL     = lob_pkg::MAX_LEVELS_DEF;
   localparam int N_RANDOM  = 1050;
   localparam int CYC_LIMIT = 400000;
   localparam logic [lob_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [lob_pkg::STATUS_BITS-1:0] status;
      logic                            bid_v;
      logic [lob_pkg::PRICE_BITS-1:0]  bid_px;
      logic [lob_pkg::TOTAL_BITS-1:0]  bid_tot;
      logic                            ask_v;
      logic [lob_pkg::PRICE_BITS-1:0]  ask_px;
      logic [lob_pkg::TOTAL_BITS-1:0]  ask_tot;
   } book_top_type;

   typedef struct {
      logic [1:0]                      cmd;
      logic [lob_pkg::ID_BITS-1:0]     id;
      logic                            side;
      logic [lob_pkg::PRICE_BITS-1:0]  px;
      logic [lob_pkg::QTY_BITS-1:0]    qty;
      bit                              fixed;
      logic [lob_pkg::STATUS_BITS-1:0] st;
   } order_cmd_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [87:0]   req_tdata = '0;   // order_id, side, price, quantity, zero pad
   logic [1:0]    req_tuser = '0;   // command
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;        // bid valid, bid price, bid total, ask valid,
                                    // ask price, ask total, zero pad
   logic [2:0]    rsp_tuser;        // status

   limit_order_book_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // book mirror
   bit                             ord_vld [N_ORD];
   logic [lob_pkg::ID_BITS-1:0]    ord_id  [N_ORD];
   logic                           ord_side[N_ORD];
   logic [lob_pkg::PRICE_BITS-1:0] ord_px  [N_ORD];
   logic [lob_pkg::QTY_BITS-1:0]   ord_qty [N_ORD];
   bit                             lvl_vld [2][N_LVL];
   logic [lob_pkg::PRICE_BITS-1:0] lvl_px  [2][N_LVL];
   logic [lob_pkg::TOTAL_BITS-1:0] lvl_tot [2][N_LVL];
   int                             lvl_cnt [2][N_LVL];

   book_top_type pending_tops[$];
   int           mismatches = 0;
   int           sender_idle = 0;
   int           recv_stall = 0;
   int           cycles = 0;

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int order_slot(logic [lob_pkg::ID_BITS-1:0] id);
      for (int i = 0; i < N_ORD; i++)
         if (ord_vld[i] && ord_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int level_slot(logic s, logic [lob_pkg::PRICE_BITS-1:0] p);
      for (int i = 0; i < N_LVL; i++)
         if (lvl_vld[s][i] && lvl_px[s][i] == p) return i;
      return -1;
   endfunction

   function automatic void drop_order(int o);
      int l;
      l = level_slot(ord_side[o], ord_px[o]);
      if (l >= 0) begin
         lvl_tot[ord_side[o]][l] -= ord_qty[o];
         if (lvl_cnt[ord_side[o]][l] > 0) lvl_cnt[ord_side[o]][l]--;
         if (lvl_cnt[ord_side[o]][l] == 0) lvl_vld[ord_side[o]][l] = 0;
      end
      ord_vld[o] = 0;
   endfunction

   function automatic logic [lob_pkg::STATUS_BITS-1:0] book_add(order_cmd_type c);
      int o;
      int l;
      if (c.qty == 0) return lob_pkg::ST_BAD_QTY;
      if (order_slot(c.id) >= 0) return lob_pkg::ST_DUP;
      o = -1;
      for (int i = N_ORD - 1; i >= 0; i--) if (!ord_vld[i]) o = i;
      if (o < 0) return lob_pkg::ST_FULL;
      l = level_slot(c.side, c.px);
      if (l < 0) begin
         for (int i = N_LVL - 1; i >= 0; i--) if (!lvl_vld[c.side][i]) l = i;
         if (l < 0) return lob_pkg::ST_FULL;
         lvl_vld[c.side][l] = 1;
         lvl_px[c.side][l]  = c.px;
         lvl_tot[c.side][l] = '0;
         lvl_cnt[c.side][l] = 0;
      end
      lvl_tot[c.side][l] += c.qty;
      lvl_cnt[c.side][l]++;
      ord_vld[o]  = 1;
      ord_id[o]   = c.id;
      ord_side[o] = c.side;
      ord_px[o]   = c.px;
      ord_qty[o]  = c.qty;
      return lob_pkg::ST_OK;
   endfunction

   function automatic logic [lob_pkg::STATUS_BITS-1:0] book_modify(order_cmd_type c);
      int o;
      int l;
      o = order_slot(c.id);
      if (o < 0) return lob_pkg::ST_NOT_FOUND;
      if (c.qty == 0) begin
         drop_order(o);
         return lob_pkg::ST_OK;
      end
      if (c.qty > ord_qty[o]) return lob_pkg::ST_INCREASE;
      l = level_slot(ord_side[o], ord_px[o]);
      if (l >= 0) lvl_tot[ord_side[o]][l] -= (ord_qty[o] - c.qty);
      ord_qty[o] = c.qty;
      return lob_pkg::ST_OK;
   endfunction

   // apply one command to the mirror, return status and top of book
   function automatic book_top_type book_apply(order_cmd_type c);
      book_top_type t;
      int o;
      t = '0;
      case (c.cmd)
         lob_pkg::CMD_ADD:    t.status = book_add(c);
         lob_pkg::CMD_CANCEL: begin
            o = order_slot(c.id);
            if (o < 0) t.status = lob_pkg::ST_NOT_FOUND;
            else begin
               drop_order(o);
               t.status = lob_pkg::ST_OK;
            end
         end
         lob_pkg::CMD_MODIFY: t.status = book_modify(c);
         default:             t.status = lob_pkg::ST_REJECTED;
      endcase
      for (int i = 0; i < N_LVL; i++) begin
         if (lvl_vld[0][i] && (!t.bid_v || lvl_px[0][i] > t.bid_px)) begin
            t.bid_v = 1; t.bid_px = lvl_px[0][i]; t.bid_tot = lvl_tot[0][i];
         end
         if (lvl_vld[1][i] && (!t.ask_v || lvl_px[1][i] < t.ask_px)) begin
            t.ask_v = 1; t.ask_px = lvl_px[1][i]; t.ask_tot = lvl_tot[1][i];
         end
      end
      return t;
   endfunction

   // present one command, hold until the transfer, then predict
   task automatic send_cmd(order_cmd_type c);
      book_top_type t;
      while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {3'b0, c.qty, c.px, c.side, c.id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      t = book_apply(c);
      if (c.fixed) t.status = c.st;
      pending_tops = {pending_tops, t};
   endtask

   function automatic order_cmd_type row(logic [1:0] cmd,
                                         logic [lob_pkg::ID_BITS-1:0] id,
                                         logic side,
                                         logic [lob_pkg::PRICE_BITS-1:0] px,
                                         logic [lob_pkg::QTY_BITS-1:0] qty,
                                         bit fixed,
                                         logic [lob_pkg::STATUS_BITS-1:0] st);
      order_cmd_type c;
      c.cmd = cmd; c.id = id; c.side = side; c.px = px; c.qty = qty;
      c.fixed = fixed; c.st = st;
      return c;
   endfunction

   // random command drawn from a small id and price pool
   function automatic order_cmd_type rand_cmd(int add_pct);
      order_cmd_type c;
      int o;
      int pick;
      c = row(lob_pkg::CMD_ADD, '0, 1'b0, '0, '0, 1'b0, lob_pkg::ST_OK);
      pick = $urandom_range(99);
      if (pick < add_pct) c.cmd = lob_pkg::CMD_ADD;
      else if (pick < add_pct + (100 - add_pct) / 2) c.cmd = lob_pkg::CMD_CANCEL;
      else if (pick < 98) c.cmd = lob_pkg::CMD_MODIFY;
      else c.cmd = CMD_UNUSED;
      c.id   = ($urandom_range(9) == 0) ? $urandom : $urandom_range(399);
      c.side = 1'($urandom_range(1));
      c.px   = lob_pkg::PRICE_BITS'(($urandom_range(7) == 0) ?
                                    $urandom_range(20'hFFFFF) :
                                    $urandom_range(1000, 1100));
      c.qty  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 5000);
      if ($urandom_range(19) == 0) c.qty = '0;
      o = order_slot(c.id);
      if (c.cmd == lob_pkg::CMD_MODIFY && o >= 0 && $urandom_range(3) != 0)
         c.qty = $urandom_range(ord_qty[o]);
      return c;
   endfunction

   // response side: random backpressure and field compare
   initial begin
      book_top_type e;
      book_top_type a;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            a.status  = rsp_tuser;
            a.bid_v   = rsp_tdata[0];
            a.bid_px  = rsp_tdata[20:1];
            a.bid_tot = rsp_tdata[60:21];
            a.ask_v   = rsp_tdata[61];
            a.ask_px  = rsp_tdata[81:62];
            a.ask_tot = rsp_tdata[121:82];
            if (pending_tops.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", a);
            end else begin
               e = pending_tops.pop_front();
               if (e.status !== a.status || e.bid_v !== a.bid_v ||
                   e.bid_px !== a.bid_px || e.bid_tot !== a.bid_tot ||
                   e.ask_v !== a.ask_v || e.ask_px !== a.ask_px ||
                   e.ask_tot !== a.ask_tot) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", e, a);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYC_LIMIT) begin
         $display("limit_order_book_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin
      order_cmd_type dir[$];
      int idle_pct[4] = '{0, 68, 0, 24};
      int stall_pct[4] = '{0, 0, 68, 24};
      int add_pct[4] = '{85, 60, 40, 55};
      int wait_cyc;

      // directed: empty book, extremes, every command, every error code but full
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd5, 1'b0, '0, '0, 1'b1,
                      lob_pkg::ST_NOT_FOUND)};
      dir = {dir, row(lob_pkg::CMD_MODIFY, 32'd5, 1'b0, '0, 32'd3, 1'b1,
                      lob_pkg::ST_NOT_FOUND)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd1, 1'b0, 20'd10, '0, 1'b1,
                      lob_pkg::ST_BAD_QTY)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd0, 1'b0, 20'd0, 32'hFFFFFFFF, 1'b1,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'hFFFFFFFF, 1'b1, 20'hFFFFF, 32'd1, 1'b1,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd0, 1'b1, 20'd7, 32'd9, 1'b1,
                      lob_pkg::ST_DUP)};
      dir = {dir, row(lob_pkg::CMD_MODIFY, 32'hFFFFFFFF, 1'b0, '0, 32'd2, 1'b1,
                      lob_pkg::ST_INCREASE)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd7, 1'b0, 20'd0, 32'hFFFFFFFF, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd8, 1'b1, 20'hFFFFF, 32'hFFFFFFFF, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd9, 1'b0, 20'd300, 32'd40, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_ADD, 32'd10, 1'b1, 20'd500, 32'd60, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_MODIFY, 32'd0, 1'b0, '0, 32'd100, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_MODIFY, 32'd8, 1'b0, '0, 32'hFFFFFFFF, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(CMD_UNUSED, 32'd7, 1'b1, 20'hFFFFF, 32'hFFFFFFFF, 1'b1,
                      lob_pkg::ST_REJECTED)};
      dir = {dir, row(lob_pkg::CMD_MODIFY, 32'd9, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd10, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd10, 1'b0, '0, '0, 1'b1,
                      lob_pkg::ST_NOT_FOUND)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd0, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd7, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'hFFFFFFFF, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};
      dir = {dir, row(lob_pkg::CMD_CANCEL, 32'd8, 1'b0, '0, '0, 1'b0,
                      lob_pkg::ST_OK)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir[i]) send_cmd(dir[i]);

      // random traffic in backpressure phases
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle = idle_pct[ph];
         recv_stall  = stall_pct[ph];
         for (int n = 0; n < N_RANDOM / 4; n++) send_cmd(rand_cmd(add_pct[ph]));
         if (ph == 1) begin
            // drain everything before going on
            req_tvalid <= 1'b0;
            while (pending_tops.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      wait_cyc = 0;
      while (pending_tops.size() != 0 && wait_cyc < 20000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_tops.size() == 0)
         $display("limit_order_book_unit_tb: PASS");
      else
         $display("limit_order_book_unit_tb: FAIL");
      $finish;
   end

endmodule
